// ===== hw/rtl/wsmh_pkg.sv =====
// ----------------------------------------------------------------------------
// wsmh_pkg
// Shared types and constants for the whitespace skipping hash block.
// ----------------------------------------------------------------------------
package wsmh_pkg;

    localparam int unsigned HASH_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 3;

    localparam logic [HASH_W-1:0] SEED_XOR       = 32'd1;
    localparam int unsigned       MIX_SHIFT      = 24;
    localparam int unsigned       AVAL_SHIFT_A   = 13;
    localparam int unsigned       AVAL_SHIFT_B   = 15;

    localparam logic [HASH_W-1:0] MULTIPLIER_RST = 32'd1540483477;
    localparam logic [HASH_W-1:0] LENGTH_RST     = 32'd0;
    localparam logic [BYTE_W-1:0] SKIP_A_RST     = 8'd9;
    localparam logic [BYTE_W-1:0] SKIP_B_RST     = 8'd10;
    localparam logic [BYTE_W-1:0] SKIP_C_RST     = 8'd13;
    localparam logic [BYTE_W-1:0] SKIP_D_RST     = 8'd32;

    // configuration register indexes
    typedef enum logic [INDEX_W-1:0] {
        REG_MULTIPLIER = 3'd0,
        REG_LENGTH     = 3'd1,
        REG_SKIP_A     = 3'd2,
        REG_SKIP_B     = 3'd3,
        REG_SKIP_C     = 3'd4,
        REG_SKIP_D     = 3'd5
    } wsmh_reg_index_t;

    typedef struct packed {
        logic [HASH_W-1:0] multiplier;
        logic [HASH_W-1:0] message_length;
        logic [BYTE_W-1:0] skip_code_a;
        logic [BYTE_W-1:0] skip_code_b;
        logic [BYTE_W-1:0] skip_code_c;
        logic [BYTE_W-1:0] skip_code_d;
    } wsmh_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_K,
        ST_MUL_P,
        ST_MUL_H,
        ST_TAIL,
        ST_AVAL,
        ST_FINISH
    } wsmh_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_MUL_K,
        OP_MUL_P,
        OP_MUL_H,
        OP_TAIL,
        OP_AVAL,
        OP_FINISH
    } wsmh_op_t;

    typedef struct packed {
        wsmh_op_t op;
    } wsmh_cmd_t;

    typedef struct packed {
        logic word_full;
        logic final_byte;
    } wsmh_status_t;

endpackage

// ===== hw/rtl/wsmh_if.sv =====
// ----------------------------------------------------------------------------
// wsmh_byte_if / wsmh_hash_if
// Valid/ready channels for message bytes in and finished hashes out.
// ----------------------------------------------------------------------------
interface wsmh_byte_if;
    import wsmh_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;
    logic              final_byte;

    modport source (output valid, output byte_value, output final_byte, input ready);
    modport sink   (input valid, input byte_value, input final_byte, output ready);
endinterface

interface wsmh_hash_if;
    import wsmh_pkg::*;
    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

// ===== hw/rtl/wsmh_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// wsmh_cfg_regs
// Write-only configuration registers: multiplier, length and skip codes.
// ----------------------------------------------------------------------------
module wsmh_cfg_regs
    import wsmh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [HASH_W-1:0]  cfg_data,
    output wsmh_cfg_t          cfg
);

    wsmh_cfg_t cfg_reg;
    wsmh_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MULTIPLIER: cfg_next.multiplier     = cfg_data;
                REG_LENGTH:     cfg_next.message_length = cfg_data;
                REG_SKIP_A:     cfg_next.skip_code_a    = cfg_data[BYTE_W-1:0];
                REG_SKIP_B:     cfg_next.skip_code_b    = cfg_data[BYTE_W-1:0];
                REG_SKIP_C:     cfg_next.skip_code_c    = cfg_data[BYTE_W-1:0];
                REG_SKIP_D:     cfg_next.skip_code_d    = cfg_data[BYTE_W-1:0];
                default:        cfg_next = cfg_reg; // unknown index ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.multiplier     <= MULTIPLIER_RST;
            cfg_reg.message_length <= LENGTH_RST;
            cfg_reg.skip_code_a    <= SKIP_A_RST;
            cfg_reg.skip_code_b    <= SKIP_B_RST;
            cfg_reg.skip_code_c    <= SKIP_C_RST;
            cfg_reg.skip_code_d    <= SKIP_D_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/wsmh_datapath.sv =====
// ----------------------------------------------------------------------------
// wsmh_datapath
// Byte packing, shared multiplier and hash registers.
// ----------------------------------------------------------------------------
module wsmh_datapath
    import wsmh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  wsmh_cfg_t         cfg,
    input  wsmh_cmd_t         cmd,
    input  logic [BYTE_W-1:0] byte_value,
    input  logic              final_byte,
    output wsmh_status_t      status,
    output logic [HASH_W-1:0] hash_value
);

    logic [HASH_W-1:0] hash_reg,   hash_next;
    logic [HASH_W-1:0] word_reg,   word_next;
    logic [1:0]        count_reg,  count_next;
    logic [HASH_W-1:0] tmp_reg,    tmp_next;
    logic              open_reg,   open_next;
    logic [HASH_W-1:0] result_reg, result_next;

    logic              kept;
    logic [4:0]        byte_shift;
    logic [HASH_W-1:0] word_packed;
    logic [HASH_W-1:0] hash_base;
    logic [HASH_W-1:0] mul_a;
    logic [HASH_W-1:0] product;

    assign kept = !(byte_value == cfg.skip_code_a || byte_value == cfg.skip_code_b ||
                    byte_value == cfg.skip_code_c || byte_value == cfg.skip_code_d);

    assign byte_shift  = {count_reg, 3'b000};
    assign word_packed = word_reg | ({{(HASH_W-BYTE_W){1'b0}}, byte_value} << byte_shift);
    assign hash_base   = open_reg ? hash_reg : (SEED_XOR ^ cfg.message_length);

    // one multiplier, operand chosen by the current step
    always_comb
    begin
        case (cmd.op)
            OP_MUL_K: mul_a = word_reg;
            OP_MUL_P: mul_a = tmp_reg ^ (tmp_reg >> MIX_SHIFT);
            OP_TAIL:  mul_a = hash_reg ^ word_reg;
            OP_AVAL:  mul_a = hash_reg ^ (hash_reg >> AVAL_SHIFT_A);
            default:  mul_a = hash_reg;
        endcase
    end

    assign product = mul_a * cfg.multiplier;

    always_comb
    begin
        hash_next   = hash_reg;
        word_next   = word_reg;
        count_next  = count_reg;
        tmp_next    = tmp_reg;
        open_next   = open_reg;
        result_next = result_reg;
        unique case (cmd.op)
            OP_ACCEPT:
            begin
                hash_next = hash_base;
                open_next = 1'b1;
                if (kept)
                begin
                    word_next  = word_packed;
                    count_next = count_reg + 2'd1;
                end
            end
            OP_MUL_K:
            begin
                tmp_next  = product;
                word_next = '0;
            end
            OP_MUL_P: tmp_next  = product;
            OP_MUL_H: hash_next = product ^ tmp_reg;
            OP_TAIL:
            begin
                if (count_reg != 2'd0)
                begin
                    hash_next = product;
                end
            end
            OP_AVAL:  hash_next = product;
            OP_FINISH:
            begin
                result_next = hash_reg ^ (hash_reg >> AVAL_SHIFT_B);
                open_next   = 1'b0;
                word_next   = '0;
                count_next  = 2'd0;
            end
            default:  hash_next = hash_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg  <= '0;
            count_reg <= 2'd0;
            open_reg  <= 1'b0;
        end
        else
        begin
            word_reg  <= word_next;
            count_reg <= count_next;
            open_reg  <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg   <= hash_next;
        tmp_reg    <= tmp_next;
        result_reg <= result_next;
    end

    assign status.word_full  = kept && (count_reg == 2'd3);
    assign status.final_byte = final_byte;
    assign hash_value        = result_reg;

endmodule

// ===== hw/rtl/wsmh_ctrl.sv =====
// ----------------------------------------------------------------------------
// wsmh_ctrl
// Sequencer for byte intake, word folding, finish and result handoff.
// ----------------------------------------------------------------------------
module wsmh_ctrl
    import wsmh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  wsmh_status_t status,
    output wsmh_cmd_t    cmd
);

    wsmh_state_t state_reg, state_next;
    logic        last_reg,  last_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.word_full)
                    begin
                        state_next = ST_MUL_K;
                    end
                    else if (status.final_byte)
                    begin
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_MUL_K:  state_next = ST_MUL_P;
            ST_MUL_P:  state_next = ST_MUL_H;
            ST_MUL_H:  state_next = last_reg ? ST_TAIL : ST_IDLE;
            ST_TAIL:   state_next = ST_AVAL;
            ST_AVAL:   state_next = ST_FINISH;
            ST_FINISH: state_next = slot_free ? ST_IDLE : ST_FINISH;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? OP_ACCEPT : OP_NONE;
            end
            ST_MUL_K:  cmd.op = OP_MUL_K;
            ST_MUL_P:  cmd.op = OP_MUL_P;
            ST_MUL_H:  cmd.op = OP_MUL_H;
            ST_TAIL:   cmd.op = OP_TAIL;
            ST_AVAL:   cmd.op = OP_AVAL;
            ST_FINISH: cmd.op = slot_free ? OP_FINISH : OP_NONE;
            default:   cmd.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (state_reg == ST_IDLE && in_valid)
        begin
            last_next = status.final_byte;
        end
        if (state_reg == ST_FINISH && slot_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/whitespace_skipping_murmur2_hash.sv =====
// ----------------------------------------------------------------------------
// whitespace_skipping_murmur2_hash
// Murmur2-style 32-bit fingerprint of a byte stream with whitespace dropped.
// ----------------------------------------------------------------------------
// Bytes arrive one item at a time on byte_in, with final_byte set on the last
// byte of a message. Bytes equal to any of the four skip codes are dropped;
// the rest are packed little-endian into 32-bit words. The running hash is
// seeded with 1 xor message_length on the first byte of each message, so
// write message_length before the message starts. A byte that is dropped or
// does not complete a word is only accepted, with no fold step. A byte that
// completes a word also runs the word fold: three multiplies through the
// single shared 32x32 multiplier, one per cycle. The final byte then adds the
// tail fold, the avalanche multiply and the loading of the output register.
// The hash is held in an output register on hash_out; the next message may
// start while it waits, and the block only stalls if a second hash finishes
// before the first one is taken.
module whitespace_skipping_murmur2_hash
    import wsmh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [HASH_W-1:0]  cfg_data,
    wsmh_byte_if.sink          byte_in,
    wsmh_hash_if.source        hash_out
);

    wsmh_cfg_t    cfg;
    wsmh_cmd_t    cmd;
    wsmh_status_t status;

    // register file; to be written only while no message is in flight (not enforced)
    wsmh_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: intake, fold steps, tail and avalanche, result handoff
    wsmh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (byte_in.valid),
        .in_ready  (byte_in.ready),
        .out_valid (hash_out.valid),
        .out_ready (hash_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // packing, multiplier and hash state
    wsmh_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .byte_value (byte_in.byte_value),
        .final_byte (byte_in.final_byte),
        .status     (status),
        .hash_value (hash_out.hash_value)
    );

endmodule
